@@ rtl/porpm_pkg.sv @@
// ----------------------------------------------------------------------------
// porpm_pkg: shared types and constants for the pen report mapper
// Field widths, register codes and the square-root step used by the pipeline.
// ----------------------------------------------------------------------------
package porpm_pkg;

	localparam int unsigned BTN_W   = 3;
	localparam int unsigned COORD_W = 15;
	localparam int unsigned PRESS_W = 13;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 3;

	localparam logic [COORD_W-1:0] COORD_MAX  = 15'd32767;
	localparam logic [PRESS_W-1:0] PRESS_MAX  = 13'd8191;
	localparam logic [PRESS_W-1:0] PRESS_ON   = 13'd4095;
	localparam logic [6:0]         SQRT_GAIN  = 7'd90;
	localparam logic [PRESS_W-1:0] BOOST_KNEE = 13'd6144;
	// ceil(2^17 / 3): exact floor division by three for values below 2^17
	localparam logic [15:0]        RECIP3     = 16'd43691;
	localparam int unsigned        RECIP3_SH  = 17;

	localparam logic [BTN_W-1:0] BTN_TIP     = 3'h1;
	localparam logic [BTN_W-1:0] BTN_BARREL  = 3'h2;
	localparam logic [BTN_W-1:0] BTN_BARREL2 = 3'h4;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE  = 1'd1;

	typedef enum logic [1:0] {
		ORIENT_NONE  = 2'd0,
		ORIENT_RIGHT = 2'd1,
		ORIENT_180   = 2'd2,
		ORIENT_LEFT  = 2'd3
	} orient_t;

	typedef enum logic [2:0] {
		CURVE_LINEAR = 3'd0,
		CURVE_ONOFF  = 3'd1,
		CURVE_SQRT   = 3'd2,
		CURVE_SQUARE = 3'd3,
		CURVE_BOOST  = 3'd4
	} curve_t;

	typedef struct packed {
		logic [PRESS_W-1:0] rem;
		logic [PRESS_W:0]   root;
	} sqrt_t;

	// One digit of the bit-by-bit floor square root; k selects bit 4^k.
	function automatic sqrt_t sqrt_step(sqrt_t st, int unsigned k);
		logic [PRESS_W:0] bitv;
		logic [PRESS_W:0] trial;
		sqrt_t            nx;
		bitv  = (PRESS_W+1)'(1) << (2 * k);
		trial = st.root + bitv;
		if ({1'b0, st.rem} >= trial) begin
			nx.rem  = st.rem - trial[PRESS_W-1:0];
			nx.root = (st.root >> 1) + bitv;
		end else begin
			nx.rem  = st.rem;
			nx.root = st.root >> 1;
		end
		return nx;
	endfunction

endpackage

@@ rtl/porpm_report_if.sv @@
// ----------------------------------------------------------------------------
// porpm_report_if: pen report channel
// Valid/ready channel carrying one decoded pen report.
// ----------------------------------------------------------------------------
interface porpm_report_if;
	logic                          valid;
	logic                          ready;
	logic [porpm_pkg::BTN_W-1:0]   button_bits;
	logic [porpm_pkg::COORD_W-1:0] x_position;
	logic [porpm_pkg::COORD_W-1:0] y_position;
	logic [porpm_pkg::PRESS_W-1:0] pressure_level;

	modport source (output valid, button_bits, x_position, y_position, pressure_level,
		input ready);
	modport sink (input valid, button_bits, x_position, y_position, pressure_level,
		output ready);
endinterface

@@ rtl/porpm_result_if.sv @@
// ----------------------------------------------------------------------------
// porpm_result_if: mapped pen result channel
// Valid/ready channel carrying button flags, mapped position and pressure.
// ----------------------------------------------------------------------------
interface porpm_result_if;
	logic                          valid;
	logic                          ready;
	logic                          tip_touch;
	logic                          barrel_button;
	logic                          second_barrel;
	logic [porpm_pkg::COORD_W-1:0] x_out;
	logic [porpm_pkg::COORD_W-1:0] y_out;
	logic [porpm_pkg::PRESS_W-1:0] pressure_shaped;

	modport source (output valid, tip_touch, barrel_button, second_barrel, x_out, y_out,
		pressure_shaped, input ready);
	modport sink (input valid, tip_touch, barrel_button, second_barrel, x_out, y_out,
		pressure_shaped, output ready);
endinterface

@@ rtl/pen_report_orient_pressure_map.sv @@
// ----------------------------------------------------------------------------
// pen_report_orient_pressure_map: pen report orientation and pressure mapper
// Remaps pen position by orientation and shapes pressure by a response curve.
// ----------------------------------------------------------------------------
// Usage:
//   report : sink channel, one decoded pen report per transfer.
//   result : source channel, one mapped result per accepted report, in order.
//   wr_en/wr_index/wr_data : register writes, index 0 orientation, index 1
//   pressure curve; write only while no report is in flight.
// A report passes through three register stages (orientation and products,
// square-root tail and division fix-up, gain multiply and output register)
// before its result is shown. Throughput is one report per cycle unless the
// receiver stalls; each stage takes a new item whenever it is empty or its
// successor advances, so bubbles collapse.
// Reset clears all valid bits and sets orientation none and linear curve.
// When the receiver stalls, the result stage holds; earlier stages fill up
// and report.ready drops once every stage is occupied. Nothing is dropped.
// ----------------------------------------------------------------------------
module pen_report_orient_pressure_map (
	input  logic                              clk,
	input  logic                              arst_n,
	porpm_report_if.sink                      report,
	porpm_result_if.source                    result,
	input  logic                              wr_en,
	input  logic [porpm_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [porpm_pkg::CFG_DATA_W-1:0]  wr_data
);
	import porpm_pkg::*;

	// configuration
	orient_t      orient_q;
	logic [2:0]   curve_q;

	// stage handshake
	logic v1_s1, v2_s2, v3_s3;
	logic ld1, ld2, ld3;

	// stage 1
	logic [BTN_W-1:0]   btn_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [PRESS_W-1:0] p_s1;
	logic [2*PRESS_W-1:0] sq_s1;
	logic [30:0]        boost_s1;
	logic               knee_s1;
	sqrt_t              rt_s1;

	// stage 2
	logic [BTN_W-1:0]   btn_s2;
	logic [COORD_W-1:0] x_s2, y_s2;
	logic [PRESS_W-1:0] pm_s2;
	logic [6:0]         root_s2;

	// stage 3 (output register)
	logic [BTN_W-1:0]   btn_s3;
	logic [COORD_W-1:0] x_s3, y_s3;
	logic [PRESS_W-1:0] po_s3;

	// combinational
	logic [COORD_W-1:0] x_map, y_map;
	sqrt_t              rt_head, rt_tail;
	logic [PRESS_W-1:0] sq_hi, sq_lo, sq_q, pm_next;
	logic [PRESS_W:0]   sq_sum;
	logic [PRESS_W-1:0] po_next;
	logic [13:0]        gain_prod;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= ORIENT_NONE;
			curve_q  <= CURVE_LINEAR;
		end else if (wr_en) begin
			case (wr_index)
				CFG_ORIENT: orient_q <= orient_t'(wr_data[1:0]);
				CFG_CURVE:  curve_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or its successor takes its item
	assign ld3 = !v3_s3 || result.ready;
	assign ld2 = !v2_s2 || ld3;
	assign ld1 = !v1_s1 || ld2;
	assign report.ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (ld1) v1_s1 <= report.valid;
			if (ld2) v2_s2 <= v1_s1;
			if (ld3) v3_s3 <= v2_s2;
		end
	end

	// stage 1: orientation, products and the upper square-root digits.
	// Reflection against full scale is a bitwise invert on 15 bits.
	always_comb begin
		case (orient_q)
			ORIENT_RIGHT: begin
				x_map = COORD_MAX - report.y_position;
				y_map = report.x_position;
			end
			ORIENT_180: begin
				x_map = COORD_MAX - report.x_position;
				y_map = COORD_MAX - report.y_position;
			end
			ORIENT_LEFT: begin
				x_map = report.y_position;
				y_map = COORD_MAX - report.x_position;
			end
			default: begin
				x_map = report.x_position;
				y_map = report.y_position;
			end
		endcase
	end

	always_comb begin
		rt_head.rem  = report.pressure_level;
		rt_head.root = '0;
		for (int k = 6; k >= 4; k--) begin
			rt_head = sqrt_step(rt_head, k);
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			btn_s1   <= report.button_bits;
			x_s1     <= x_map;
			y_s1     <= y_map;
			p_s1     <= report.pressure_level;
			sq_s1    <= report.pressure_level * report.pressure_level;
			boost_s1 <= {report.pressure_level, 2'b00} * RECIP3;
			knee_s1  <= report.pressure_level >= BOOST_KNEE;
			rt_s1    <= rt_head;
		end
	end

	// stage 2: lower square-root digits, division fix-ups, curve select.
	// n / 8191 with n = a*8192 + b is a + ((a + b) >= 8191), since a + b
	// stays below twice the divisor.
	always_comb begin
		rt_tail = rt_s1;
		for (int k = 3; k >= 0; k--) begin
			rt_tail = sqrt_step(rt_tail, k);
		end
	end

	assign sq_hi  = sq_s1[2*PRESS_W-1:PRESS_W];
	assign sq_lo  = sq_s1[PRESS_W-1:0];
	assign sq_sum = {1'b0, sq_hi} + {1'b0, sq_lo};
	assign sq_q   = sq_hi + PRESS_W'(sq_sum >= {1'b0, PRESS_MAX});

	always_comb begin
		case (curve_q)
			CURVE_ONOFF:  pm_next = (p_s1 != '0) ? PRESS_ON : '0;
			CURVE_SQUARE: pm_next = sq_q;
			CURVE_BOOST:  pm_next = knee_s1 ? PRESS_MAX :
				boost_s1[RECIP3_SH +: PRESS_W];
			default:      pm_next = p_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			btn_s2  <= btn_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			pm_s2   <= pm_next;
			root_s2 <= rt_tail.root[6:0];
		end
	end

	// stage 3: gain on the square root, then hold in the output register
	assign gain_prod = root_s2 * SQRT_GAIN;
	assign po_next   = (curve_q == CURVE_SQRT) ? gain_prod[PRESS_W-1:0] : pm_s2;

	always_ff @(posedge clk) begin
		if (ld3) begin
			btn_s3 <= btn_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			po_s3  <= po_next;
		end
	end

	assign result.valid           = v3_s3;
	assign result.tip_touch       = (btn_s3 & BTN_TIP) != '0;
	assign result.barrel_button   = (btn_s3 & BTN_BARREL) != '0;
	assign result.second_barrel   = (btn_s3 & BTN_BARREL2) != '0;
	assign result.x_out           = x_s3;
	assign result.y_out           = y_s3;
	assign result.pressure_shaped = po_s3;

	// an item in stage one moves into stage two when that stage loads
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && ld2) |=> v2_s2)
		else $error("stage two lost an advancing item");

	// a stalled result stage keeps its item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && !result.ready) |=> (v3_s3 && $stable(po_s3) && $stable(x_s3)))
		else $error("output stage changed under stall");

	// square-root curve never exceeds 90 times the largest root
	a_sqrt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && curve_q == CURVE_SQRT) |-> (po_s3 <= PRESS_W'(8100)))
		else $error("square-root pressure out of range");

	// on/off curve gives only zero or the on level
	a_onoff: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && curve_q == CURVE_ONOFF) |-> (po_s3 == '0 || po_s3 == PRESS_ON))
		else $error("on/off pressure not a legal level");

endmodule
